// ----- hdl/gamepad_deadzone_conditioner_macros.svh -----
// Assertion helpers for the deadzone conditioner checker.
`ifndef GAMEPAD_DEADZONE_CONDITIONER_MACROS_SVH
`define GAMEPAD_DEADZONE_CONDITIONER_MACROS_SVH

// Clocked assertion, off while in reset.
`define GDZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GDZ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/gdz_pkg.sv -----
`default_nettype none
package gdz_pkg;

  localparam int PAD_COUNT    = 4;
  localparam int BUTTON_COUNT = 14;

  localparam int PAD_W  = 2;
  localparam int BTN_W  = 14;
  localparam int TRIG_W = 8;
  localparam int AXIS_W = 16;
  localparam int MAG_W  = 15;
  localparam int DZ_W   = 15;

  localparam int NUM_W  = 56;
  localparam int DEN_W  = 40;
  localparam int Q_W    = 16;
  localparam int RAD_W  = 48;
  localparam int ROOT_W = 24;

  localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((64'd1 << BUTTON_COUNT) - 64'd1);

  localparam logic [MAG_W-1:0]  FULL_STICK   = 15'h7FFF;
  localparam logic [Q_W-1:0]    FULL_TRIGGER = 16'hFFFF;
  localparam logic [TRIG_W-1:0] TRIG_TOP     = 8'hFF;

  localparam logic [1:0] CFG_TRIG_DZ  = 2'd0;
  localparam logic [1:0] CFG_LEFT_DZ  = 2'd1;
  localparam logic [1:0] CFG_RIGHT_DZ = 2'd2;

  localparam logic [TRIG_W-1:0] TRIG_DZ_RST  = 8'd30;
  localparam logic [DZ_W-1:0]   LEFT_DZ_RST  = 15'd7849;
  localparam logic [DZ_W-1:0]   RIGHT_DZ_RST = 15'd8689;

endpackage
`default_nettype wire

// ----- hdl/gamepad_deadzone_conditioner.sv -----
// Scaled radial deadzone conditioner for up to four game pads.
// Input channel (in_valid_i/in_ready_o) takes one frame sample per beat:
// pad index, presence, two triggers, two sticks and the button mask.
// Output channel (out_valid_o/out_ready_i) gives one conditioned result
// per beat. Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) set the
// trigger and stick deadzones and take effect at once.
// The stick path is the longest: squaring, a bit-serial square root, a
// shift-add multiply and a restoring divide, both sticks and both triggers
// running side by side. It is shorter when both sticks sit in their
// deadzones. One sample is in work at a time; a new one is taken only once
// the last result has moved to the output register.
// A finished result sits in the output register; the next sample is taken
// while it waits. If the receiver stalls, the following result is held
// inside until the output register frees up.
// Reset clears the per-pad button and presence history, the output valid
// and restores the deadzone registers to their defaults.
`default_nettype none
module gamepad_deadzone_conditioner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [gdz_pkg::DZ_W-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gdz_pkg::PAD_W-1:0]         pad_index_i,
  input  logic                              pad_present_i,
  input  logic [gdz_pkg::TRIG_W-1:0]        left_trigger_raw_i,
  input  logic [gdz_pkg::TRIG_W-1:0]        right_trigger_raw_i,
  input  logic signed [gdz_pkg::AXIS_W-1:0] left_x_raw_i,
  input  logic signed [gdz_pkg::AXIS_W-1:0] left_y_raw_i,
  input  logic signed [gdz_pkg::AXIS_W-1:0] right_x_raw_i,
  input  logic signed [gdz_pkg::AXIS_W-1:0] right_y_raw_i,
  input  logic [gdz_pkg::BTN_W-1:0]         button_mask_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gdz_pkg::PAD_W-1:0]         pad_number_o,
  output logic [gdz_pkg::Q_W-1:0]           left_trigger_out_o,
  output logic [gdz_pkg::Q_W-1:0]           right_trigger_out_o,
  output logic signed [gdz_pkg::AXIS_W-1:0] left_x_out_o,
  output logic signed [gdz_pkg::AXIS_W-1:0] left_y_out_o,
  output logic signed [gdz_pkg::AXIS_W-1:0] right_x_out_o,
  output logic signed [gdz_pkg::AXIS_W-1:0] right_y_out_o,
  output logic [gdz_pkg::BTN_W-1:0]         buttons_held_o,
  output logic [gdz_pkg::BTN_W-1:0]         buttons_pressed_o,
  output logic [gdz_pkg::BTN_W-1:0]         buttons_released_o,
  output logic                              connect_edge_o,
  output logic                              disconnect_edge_o
);
  import gdz_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  localparam logic signed [AXIS_W-1:0] AXIS_MIN = {1'b1, {(AXIS_W-1){1'b0}}};

  state_e            state_q;
  logic              start_q;
  logic [TRIG_W-1:0] trig_dz_q;
  logic [DZ_W-1:0]   left_dz_q, right_dz_q;
  logic [BTN_W-1:0]  prev_btn_q [PAD_COUNT];
  logic [PAD_COUNT-1:0] prev_pres_q;

  logic [PAD_W-1:0]  pad_q;
  logic              active_q, conn_q, disc_q;
  logic [BTN_W-1:0]  held_q, pressed_q, released_q;
  logic [TRIG_W-1:0] ltr_q, rtr_q;
  logic signed [AXIS_W-1:0] lx_q, ly_q, rx_q, ry_q;

  logic              out_valid_q;
  logic [PAD_W-1:0]  o_pad_q;
  logic [Q_W-1:0]    o_lt_q, o_rt_q;
  logic signed [AXIS_W-1:0] o_lx_q, o_ly_q, o_rx_q, o_ry_q;
  logic [BTN_W-1:0]  o_held_q, o_pressed_q, o_released_q;
  logic              o_conn_q, o_disc_q;

  logic              accept, pad_ok, prev_pres;
  logic [BTN_W-1:0]  held_in, prev_btn;
  logic              lt_busy, rt_busy, ls_busy, rs_busy, done, load;
  logic [TRIG_W-1:0] trig_den;
  logic [Q_W-1:0]    lt_quot, rt_quot, lt_val, rt_val;
  logic signed [AXIS_W-1:0] ls_x, ls_y, rs_x, rs_y;

  function automatic logic [NUM_W-1:0] trig_num(input logic [TRIG_W-1:0] raw,
                                                input logic [TRIG_W-1:0] dz);
    logic [NUM_W-1:0] diff;
    logic [NUM_W-1:0] den;
    diff = NUM_W'(raw - dz);
    den  = NUM_W'(TRIG_TOP - dz);
    return (diff << Q_W) - diff + (den >> 1);
  endfunction

  function automatic logic [Q_W-1:0] trig_sel(input logic [TRIG_W-1:0] raw,
                                              input logic [TRIG_W-1:0] dz,
                                              input logic [Q_W-1:0] quot);
    logic [Q_W-1:0] res;
    if (raw < dz) begin
      res = '0;
    end else if (dz == TRIG_TOP) begin
      res = FULL_TRIGGER;
    end else begin
      res = quot;
    end
    return res;
  endfunction

  function automatic logic signed [AXIS_W-1:0] clamp_pos(input logic signed [AXIS_W-1:0] v);
    return (v == AXIS_MIN) ? -$signed({1'b0, FULL_STICK}) : v;
  endfunction

  function automatic logic signed [AXIS_W-1:0] clamp_neg(input logic signed [AXIS_W-1:0] v);
    return (v == AXIS_MIN) ? $signed({1'b0, FULL_STICK}) : -v;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign pad_ok     = 32'(pad_index_i) < PAD_COUNT;
  assign prev_pres  = pad_ok && prev_pres_q[pad_index_i];
  assign prev_btn   = pad_ok ? prev_btn_q[pad_index_i] : '0;
  assign held_in    = button_mask_i & BTN_MASK;
  assign trig_den   = TRIG_TOP - trig_dz_q;

  gdz_div u_ltrig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .num_i   (trig_num(ltr_q, trig_dz_q)),
    .den_i   (DEN_W'(trig_den)),
    .busy_o  (lt_busy),
    .quot_o  (lt_quot)
  );

  gdz_div u_rtrig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .num_i   (trig_num(rtr_q, trig_dz_q)),
    .den_i   (DEN_W'(trig_den)),
    .busy_o  (rt_busy),
    .quot_o  (rt_quot)
  );

  gdz_stick u_lstick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .x_i     (lx_q),
    .y_i     (ly_q),
    .dz_i    (left_dz_q),
    .busy_o  (ls_busy),
    .x_o     (ls_x),
    .y_o     (ls_y)
  );

  gdz_stick u_rstick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .x_i     (rx_q),
    .y_i     (ry_q),
    .dz_i    (right_dz_q),
    .busy_o  (rs_busy),
    .x_o     (rs_x),
    .y_o     (rs_y)
  );

  assign lt_val = trig_sel(ltr_q, trig_dz_q, lt_quot);
  assign rt_val = trig_sel(rtr_q, trig_dz_q, rt_quot);
  assign done   = (state_q == ST_RUN) && !start_q && !lt_busy && !rt_busy
                  && !ls_busy && !rs_busy;
  assign load   = done && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      trig_dz_q   <= TRIG_DZ_RST;
      left_dz_q   <= LEFT_DZ_RST;
      right_dz_q  <= RIGHT_DZ_RST;
      prev_pres_q <= '0;
      for (int i = 0; i < PAD_COUNT; i++) begin
        prev_btn_q[i] <= '0;
      end
    end else begin
      start_q <= accept;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TRIG_DZ:  trig_dz_q  <= cfg_data_i[TRIG_W-1:0];
          CFG_LEFT_DZ:  left_dz_q  <= cfg_data_i;
          CFG_RIGHT_DZ: right_dz_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_RUN;
            if (pad_ok) begin
              prev_pres_q[pad_index_i] <= pad_present_i;
              prev_btn_q[pad_index_i]  <= pad_present_i ? held_in : '0;
            end
          end
        end
        ST_RUN: begin
          if (load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pad_q      <= pad_index_i;
      active_q   <= pad_ok && pad_present_i;
      conn_q     <= pad_ok && pad_present_i && !prev_pres;
      disc_q     <= pad_ok && !pad_present_i && prev_pres;
      held_q     <= held_in;
      pressed_q  <= held_in & ~prev_btn;
      released_q <= prev_btn & ~held_in;
      ltr_q      <= left_trigger_raw_i;
      rtr_q      <= right_trigger_raw_i;
      lx_q       <= clamp_pos(left_x_raw_i);
      ly_q       <= clamp_neg(left_y_raw_i);
      rx_q       <= clamp_pos(right_x_raw_i);
      ry_q       <= clamp_neg(right_y_raw_i);
    end
    if (load) begin
      o_pad_q      <= pad_q;
      o_conn_q     <= conn_q;
      o_disc_q     <= disc_q;
      o_lt_q       <= active_q ? lt_val : '0;
      o_rt_q       <= active_q ? rt_val : '0;
      o_lx_q       <= active_q ? ls_x : '0;
      o_ly_q       <= active_q ? ls_y : '0;
      o_rx_q       <= active_q ? rs_x : '0;
      o_ry_q       <= active_q ? rs_y : '0;
      o_held_q     <= active_q ? held_q : '0;
      o_pressed_q  <= active_q ? pressed_q : '0;
      o_released_q <= active_q ? released_q : '0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign pad_number_o        = o_pad_q;
  assign left_trigger_out_o  = o_lt_q;
  assign right_trigger_out_o = o_rt_q;
  assign left_x_out_o        = o_lx_q;
  assign left_y_out_o        = o_ly_q;
  assign right_x_out_o       = o_rx_q;
  assign right_y_out_o       = o_ry_q;
  assign buttons_held_o      = o_held_q;
  assign buttons_pressed_o   = o_pressed_q;
  assign buttons_released_o  = o_released_q;
  assign connect_edge_o      = o_conn_q;
  assign disconnect_edge_o   = o_disc_q;
endmodule
`default_nettype wire

// ----- hdl/gdz_div.sv -----
`default_nettype none
module gdz_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gdz_pkg::NUM_W-1:0]  num_i,
  input  logic [gdz_pkg::DEN_W-1:0]  den_i,
  output logic                       busy_o,
  output logic [gdz_pkg::Q_W-1:0]    quot_o
);
  import gdz_pkg::*;

  localparam int CNT_W = $clog2(Q_W);

  logic [NUM_W-1:0] rem_q, rem_d, dsh_q, dsh_d;
  logic [Q_W-1:0]   quot_q, quot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             ge;

  // restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    ge     = rem_q >= dsh_q;
    if (start_i) begin
      rem_d  = num_i;
      dsh_d  = NUM_W'(den_i) << (Q_W - 1);
      quot_d = '0;
      cnt_d  = CNT_W'(Q_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? rem_q - dsh_q : rem_q;
      quot_d = {quot_q[Q_W-2:0], ge};
      dsh_d  = dsh_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

// ----- hdl/gdz_isqrt.sv -----
`default_nettype none
module gdz_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gdz_pkg::RAD_W-1:0]   rad_i,
  output logic                        busy_o,
  output logic [gdz_pkg::ROOT_W-1:0]  root_o
);
  import gdz_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              ge;

  // two radicand bits in, one root bit out per cycle
  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_sh = {rem_q[ROOT_W:0], rad_q[RAD_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    ge     = rem_sh >= trial;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? rem_sh - trial : rem_sh;
      root_d = {root_q[ROOT_W-2:0], ge};
      rad_d  = rad_q << 2;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

// ----- hdl/gdz_stick.sv -----
`default_nettype none
module gdz_stick (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [gdz_pkg::AXIS_W-1:0] x_i,
  input  logic signed [gdz_pkg::AXIS_W-1:0] y_i,
  input  logic [gdz_pkg::DZ_W-1:0]          dz_i,
  output logic                              busy_o,
  output logic signed [gdz_pkg::AXIS_W-1:0] x_o,
  output logic signed [gdz_pkg::AXIS_W-1:0] y_o
);
  import gdz_pkg::*;

  localparam int MCNT_W = $clog2(MAG_W);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_TEST, ST_ROOT, ST_PREP, ST_MUL, ST_LAUNCH, ST_DIV
  } state_e;

  state_e              state_q;
  logic [MAG_W-1:0]    magx_q, magy_q;
  logic                negx_q, negy_q;
  logic [DZ_W-1:0]     dz_q;
  logic [2*MAG_W-1:0]  sxx_q, syy_q, dzsq_q;
  logic [MCNT_W-1:0]   mcnt_q;
  logic [NUM_W-1:0]    mulsh_q, accx_q, accy_q;
  logic [DEN_W-1:0]    den_q;
  logic signed [AXIS_W-1:0] x_q, y_q;

  logic [2*MAG_W:0]    ssum;
  logic                zero;
  logic                sqrt_start, sqrt_busy, div_start, divx_busy, divy_busy;
  logic [ROOT_W-1:0]   root;
  logic [ROOT_W-1:0]   d8, dz8;
  logic [DZ_W-1:0]     span;
  logic                capped;
  logic [DEN_W-1:0]    den_d;
  logic [NUM_W-1:0]    mul_d;
  logic [Q_W-1:0]      qx, qy;
  logic [MAG_W-1:0]    cx, cy;

  assign ssum = {1'b0, sxx_q} + {1'b0, syy_q};
  assign zero = (ssum == '0) || (ssum < {1'b0, dzsq_q});

  assign dz8    = {1'b0, dz_q, 8'd0};
  assign d8     = root - dz8;
  assign span   = FULL_STICK - dz_q;
  assign capped = (span == '0) || (d8 >= {1'b0, span, 8'd0});
  assign den_d  = capped ? DEN_W'(root) : DEN_W'(span) * DEN_W'(root);
  assign mul_d  = capped ? NUM_W'({FULL_STICK, 8'd0})
                         : (NUM_W'(d8) << MAG_W) - NUM_W'(d8);

  assign sqrt_start = (state_q == ST_TEST) && !zero;
  assign div_start  = (state_q == ST_LAUNCH);

  gdz_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (RAD_W'({ssum, 16'd0})),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  gdz_div u_divx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (accx_q),
    .den_i   (den_q),
    .busy_o  (divx_busy),
    .quot_o  (qx)
  );

  gdz_div u_divy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (accy_q),
    .den_i   (den_q),
    .busy_o  (divy_busy),
    .quot_o  (qy)
  );

  assign cx = (qx > Q_W'(FULL_STICK)) ? FULL_STICK : qx[MAG_W-1:0];
  assign cy = (qy > Q_W'(FULL_STICK)) ? FULL_STICK : qy[MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mcnt_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          state_q <= ST_TEST;
        end
        ST_TEST: begin
          state_q <= zero ? ST_IDLE : ST_ROOT;
        end
        ST_ROOT: begin
          if (!sqrt_busy) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          mcnt_q  <= MCNT_W'(MAG_W - 1);
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (mcnt_q == '0) begin
            state_q <= ST_LAUNCH;
          end else begin
            mcnt_q <= mcnt_q - 1'b1;
          end
        end
        ST_LAUNCH: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (!divx_busy && !divy_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          negx_q <= x_i[AXIS_W-1];
          negy_q <= y_i[AXIS_W-1];
          magx_q <= x_i[AXIS_W-1] ? MAG_W'(-x_i) : x_i[MAG_W-1:0];
          magy_q <= y_i[AXIS_W-1] ? MAG_W'(-y_i) : y_i[MAG_W-1:0];
          dz_q   <= dz_i;
        end
      end
      ST_SQ: begin
        sxx_q  <= magx_q * magx_q;
        syy_q  <= magy_q * magy_q;
        dzsq_q <= dz_q * dz_q;
      end
      ST_TEST: begin
        if (zero) begin
          x_q <= '0;
          y_q <= '0;
        end
      end
      ST_PREP: begin
        den_q   <= den_d;
        mulsh_q <= mul_d;
        accx_q  <= NUM_W'(den_d >> 1);
        accy_q  <= NUM_W'(den_d >> 1);
      end
      ST_MUL: begin
        // LSB-first shift-add, both lanes share the shifted multiplicand
        accx_q  <= accx_q + (magx_q[0] ? mulsh_q : '0);
        accy_q  <= accy_q + (magy_q[0] ? mulsh_q : '0);
        magx_q  <= magx_q >> 1;
        magy_q  <= magy_q >> 1;
        mulsh_q <= mulsh_q << 1;
      end
      ST_DIV: begin
        if (!divx_busy && !divy_busy) begin
          x_q <= negx_q ? -$signed({1'b0, cx}) : $signed({1'b0, cx});
          y_q <= negy_q ? -$signed({1'b0, cy}) : $signed({1'b0, cy});
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign x_o    = x_q;
  assign y_o    = y_q;
endmodule
`default_nettype wire

// ----- hdl/gdz_checker.sv -----
`default_nettype none
`include "gamepad_deadzone_conditioner_macros.svh"
module gdz_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [gdz_pkg::Q_W-1:0]           left_trigger_out_o,
  input logic [gdz_pkg::Q_W-1:0]           right_trigger_out_o,
  input logic [gdz_pkg::BTN_W-1:0]         buttons_held_o,
  input logic                              connect_edge_o,
  input logic                              disconnect_edge_o
);

  `GDZ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "out beat dropped")
  `GDZ_ASSERT(a_one_in_flight, in_valid_i && in_ready_o |=> !in_ready_o, "second beat taken early")
  `GDZ_ASSERT(a_edges_excl, out_valid_o |-> !(connect_edge_o && disconnect_edge_o), "both edges")
  `GDZ_ASSERT(a_disc_zero, out_valid_o && disconnect_edge_o |-> buttons_held_o == '0 && left_trigger_out_o == '0 && right_trigger_out_o == '0, "disconnect not zeroed")
endmodule

bind gamepad_deadzone_conditioner gdz_checker u_gdz_checker (.*);
`default_nettype wire

// ----- tb/tb_gamepad_deadzone_conditioner.sv -----
`default_nettype none
module tb_gamepad_deadzone_conditioner;
  timeunit 1ns;
  timeprecision 1ps;
  import gdz_pkg::*;

  typedef struct {
    logic [PAD_W-1:0]  pad;
    logic              present;
    logic [TRIG_W-1:0] lt, rt;
    logic [AXIS_W-1:0] lx, ly, rx, ry;
    logic [BTN_W-1:0]  btn;
  } sample_t;

  typedef struct {
    logic [PAD_W-1:0]  pad;
    logic [Q_W-1:0]    lt, rt;
    logic [AXIS_W-1:0] lx, ly, rx, ry;
    logic [BTN_W-1:0]  held, pressed, released;
    logic              conn, disc;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_TRIG_DZ;
  logic [DZ_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [PAD_W-1:0] pad_index_i = '0;
  logic pad_present_i = 1'b0;
  logic [TRIG_W-1:0] left_trigger_raw_i = '0, right_trigger_raw_i = '0;
  logic signed [AXIS_W-1:0] left_x_raw_i = '0, left_y_raw_i = '0;
  logic signed [AXIS_W-1:0] right_x_raw_i = '0, right_y_raw_i = '0;
  logic [BTN_W-1:0] button_mask_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [PAD_W-1:0] pad_number_o;
  logic [Q_W-1:0] left_trigger_out_o, right_trigger_out_o;
  logic signed [AXIS_W-1:0] left_x_out_o, left_y_out_o, right_x_out_o, right_y_out_o;
  logic [BTN_W-1:0] buttons_held_o, buttons_pressed_o, buttons_released_o;
  logic connect_edge_o, disconnect_edge_o;

  gamepad_deadzone_conditioner u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sample_t pending_samples[$];
  frame_t  expected_frames[$];
  int errors = 0;
  int frames_seen = 0;
  int stall_long = 0;
  bit cfg_busy = 1'b0;

  logic [7:0]  trig_dz;
  logic [14:0] left_dz, right_dz;
  logic [13:0] last_btn[PAD_COUNT];
  logic        last_present[PAD_COUNT];

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] trigger_level(logic [7:0] raw, logic [7:0] dz);
    logic [63:0] den;
    if (raw < dz) return 16'd0;
    den = 64'd255 - dz;
    if (den == 0) return FULL_TRIGGER;
    return 16'(((64'(raw - dz)) * 64'd65535 + den / 2) / den);
  endfunction

  function automatic int clamp_axis(int v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  function automatic int scale_axis(int v, logic [63:0] mul, logic [63:0] den);
    logic [63:0] mag, q;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    q = (mag * mul + den / 2) / den;
    if (q > 32767) q = 32767;
    return (v < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic void radial_stick(input int x, input int y, input logic [14:0] dz,
                                       output logic [15:0] ox, output logic [15:0] oy);
    logic [63:0] s, l8, d8, range, mul, den;
    s = 64'(x * x) + 64'(y * y);
    ox = 0;
    oy = 0;
    if (s == 0 || s < 64'(dz) * 64'(dz)) return;
    l8 = root64(s << 16);
    d8 = l8 - (64'(dz) << 8);
    range = 64'd32767 - dz;
    if (range == 0 || d8 >= (range << 8)) begin
      mul = 64'd32767 << 8;
      den = l8;
    end else begin
      mul = d8 * 64'd32767;
      den = range * l8;
    end
    ox = 16'(scale_axis(x, mul, den));
    oy = 16'(scale_axis(y, mul, den));
  endfunction

  function automatic frame_t condition_sample(sample_t s);
    frame_t f;
    f = '{default: '0};
    f.pad = s.pad;
    f.conn = s.present && !last_present[s.pad];
    f.disc = !s.present && last_present[s.pad];
    last_present[s.pad] = s.present;
    if (!s.present) begin
      last_btn[s.pad] = '0;
      return f;
    end
    f.lt = trigger_level(s.lt, trig_dz);
    f.rt = trigger_level(s.rt, trig_dz);
    radial_stick(clamp_axis(int'(signed'(s.lx))), clamp_axis(-int'(signed'(s.ly))),
                 left_dz, f.lx, f.ly);
    radial_stick(clamp_axis(int'(signed'(s.rx))), clamp_axis(-int'(signed'(s.ry))),
                 right_dz, f.rx, f.ry);
    f.held = s.btn & BTN_MASK;
    f.pressed = f.held & ~last_btn[s.pad];
    f.released = last_btn[s.pad] & ~f.held;
    last_btn[s.pad] = f.held;
    return f;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_frames.push_back(condition_sample(pending_samples.pop_front()));
        send_gap = gap_len();
      end
      if (in_valid_i && !in_ready_o) begin
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_samples.size() > 0 && !cfg_busy) begin
        in_valid_i <= 1'b1;
        pad_index_i <= pending_samples[0].pad;
        pad_present_i <= pending_samples[0].present;
        left_trigger_raw_i <= pending_samples[0].lt;
        right_trigger_raw_i <= pending_samples[0].rt;
        left_x_raw_i <= pending_samples[0].lx;
        left_y_raw_i <= pending_samples[0].ly;
        right_x_raw_i <= pending_samples[0].rx;
        right_y_raw_i <= pending_samples[0].ry;
        button_mask_i <= pending_samples[0].btn;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor
  int recv_gap = 0;
  always @(posedge clk_i) begin
    frame_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        frames_seen++;
        if (expected_frames.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = expected_frames.pop_front();
          check_field("pad_number", 16'(e.pad), 16'(pad_number_o));
          check_field("left_trigger_out", e.lt, left_trigger_out_o);
          check_field("right_trigger_out", e.rt, right_trigger_out_o);
          check_field("left_x_out", e.lx, left_x_out_o);
          check_field("left_y_out", e.ly, left_y_out_o);
          check_field("right_x_out", e.rx, right_x_out_o);
          check_field("right_y_out", e.ry, right_y_out_o);
          check_field("buttons_held", 16'(e.held), 16'(buttons_held_o));
          check_field("buttons_pressed", 16'(e.pressed), 16'(buttons_pressed_o));
          check_field("buttons_released", 16'(e.released), 16'(buttons_released_o));
          check_field("connect_edge", 16'(e.conn), 16'(connect_edge_o));
          check_field("disconnect_edge", 16'(e.disc), 16'(disconnect_edge_o));
        end
      end
      if (stall_long > 0) begin
        stall_long--;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i) recv_gap = gap_len();
      end
    end
  end

  function automatic int rand_axis();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    if (r < 5) return $urandom_range(0, 20000) - 10000;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.pad = PAD_W'($urandom_range(0, PAD_COUNT - 1));
    s.present = ($urandom_range(0, 9) != 0);
    s.lt = TRIG_W'($urandom_range(0, 255));
    s.rt = TRIG_W'($urandom_range(0, 255));
    s.lx = AXIS_W'(rand_axis());
    s.ly = AXIS_W'(rand_axis());
    s.rx = AXIS_W'(rand_axis());
    s.ry = AXIS_W'(rand_axis());
    s.btn = BTN_W'($urandom_range(0, 16383));
    return s;
  endfunction

  function automatic sample_t make_sample(int pad, bit pr, int lt, int rt,
                                          int lx, int ly, int rx, int ry, int btn);
    sample_t s;
    s.pad = PAD_W'(pad);
    s.present = pr;
    s.lt = TRIG_W'(lt);
    s.rt = TRIG_W'(rt);
    s.lx = AXIS_W'(lx);
    s.ly = AXIS_W'(ly);
    s.rx = AXIS_W'(rx);
    s.ry = AXIS_W'(ry);
    s.btn = BTN_W'(btn);
    return s;
  endfunction

  task automatic drain();
    while (pending_samples.size() > 0 || expected_frames.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_busy = 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= DZ_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TRIG_DZ) trig_dz = 8'(val);
    else if (idx == CFG_LEFT_DZ) left_dz = 15'(val);
    else right_dz = 15'(val);
    cfg_busy = 1'b0;
  endtask

  initial begin
    int phase_cfg[5][3] = '{'{0, 0, 0}, '{254, 32766, 32766}, '{255, 32767, 32767},
                            '{100, 1000, 20000}, '{30, 7849, 8689}};
    trig_dz = TRIG_DZ_RST;
    left_dz = LEFT_DZ_RST;
    right_dz = RIGHT_DZ_RST;
    for (int i = 0; i < PAD_COUNT; i++) begin
      last_btn[i] = '0;
      last_present[i] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed
    pending_samples.push_back(make_sample(0, 1, 0, 255, 0, 0, 32767, -32768, 16383));
    pending_samples.push_back(make_sample(0, 1, 29, 30, -32768, -32768, 5000, 5000, 0));
    pending_samples.push_back(make_sample(0, 0, 255, 255, 32767, 32767, 1, 1, 16383));
    pending_samples.push_back(make_sample(1, 1, 31, 254, 7849, 0, 0, -8689, 5461));
    pending_samples.push_back(make_sample(1, 1, 128, 1, 7848, 0, 0, 8688, 10922));
    pending_samples.push_back(make_sample(2, 1, 200, 100, 30000, 30000, -100, 100, 1));
    pending_samples.push_back(make_sample(3, 1, 255, 0, -32768, 0, 0, -32768, 8192));
    pending_samples.push_back(make_sample(3, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(3, 1, 0, 0, 0, 0, 0, 0, 0));
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_TRIG_DZ, phase_cfg[ph][0]);
      write_reg(CFG_LEFT_DZ, phase_cfg[ph][1]);
      write_reg(CFG_RIGHT_DZ, phase_cfg[ph][2]);
      pending_samples.push_back(make_sample(ph % 4, 1, 255, 254, 32767, 0,
                                            phase_cfg[ph][2], 0, ph));
      for (int i = 0; i < 330; i++) pending_samples.push_back(rand_sample());
      if (ph == 1) begin
        while (pending_samples.size() > 300) @(posedge clk_i);
        stall_long = 600;
      end
      drain();
    end
    $display("Sent %0d frame samples over 5 deadzone settings and directed corners.",
             frames_seen);
    $display("Checked %0d conditioned results, including a long output stall.",
             frames_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
